// ----- hdl/c39_pkg.sv -----
// Shared types, constants and lookup functions for the Code 39 encoder.
`timescale 1ns / 1ps

package c39_pkg;

  localparam int MAX_CHARS_DEF = 80;
  localparam int QDEPTH        = 2;
  localparam int MOD           = 43;

  localparam logic [5:0] SYM_STAR = 6'd43;
  localparam logic [1:0] CFG_IDX_W = 2'd1;

  // Register indexes of the configuration port.
  localparam logic CFG_WIDE_RATIO = 1'b0;
  localparam logic CFG_CHECK_EN   = 1'b1;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } in_t;

  typedef struct packed {
    logic [1:0] element_width;
    logic       is_bar;
    logic       error;
    logic       last;
  } out_t;

  // One queued unit of work for the element sequencer.
  typedef struct packed {
    logic       err;
    logic       start;
    logic [5:0] sym;
    logic       check;
    logic [5:0] check_sym;
    logic       stop;
  } job_t;

  typedef struct packed {
    logic       valid;
    logic [5:0] value;
  } sym_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_ERR,
    PH_START,
    PH_DATA,
    PH_CHECK,
    PH_STOP
  } phase_t;

  function automatic sym_t c39_sym_of(input logic [7:0] c);
    sym_t s;
    s.valid = 1'b1;
    s.value = 6'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      s.value = 6'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h5A) begin
      s.value = 6'(c - 8'h41 + 8'd10);
    end else begin
      case (c)
        8'h2D:   s.value = 6'd36;
        8'h2E:   s.value = 6'd37;
        8'h20:   s.value = 6'd38;
        8'h24:   s.value = 6'd39;
        8'h2F:   s.value = 6'd40;
        8'h2B:   s.value = 6'd41;
        8'h25:   s.value = 6'd42;
        8'h2A:   s.value = SYM_STAR;
        default: s.valid = 1'b0;
      endcase
    end
    return s;
  endfunction

  // Nine-element pattern, bit 8 printed first, 1 marks a wide element.
  function automatic logic [8:0] c39_pattern(input logic [5:0] sym);
    logic [8:0] p;
    case (sym)
      6'd0:    p = 9'h034;
      6'd1:    p = 9'h121;
      6'd2:    p = 9'h061;
      6'd3:    p = 9'h160;
      6'd4:    p = 9'h031;
      6'd5:    p = 9'h130;
      6'd6:    p = 9'h070;
      6'd7:    p = 9'h025;
      6'd8:    p = 9'h124;
      6'd9:    p = 9'h064;
      6'd10:   p = 9'h109;
      6'd11:   p = 9'h049;
      6'd12:   p = 9'h148;
      6'd13:   p = 9'h019;
      6'd14:   p = 9'h118;
      6'd15:   p = 9'h058;
      6'd16:   p = 9'h00D;
      6'd17:   p = 9'h10C;
      6'd18:   p = 9'h04C;
      6'd19:   p = 9'h01C;
      6'd20:   p = 9'h103;
      6'd21:   p = 9'h043;
      6'd22:   p = 9'h142;
      6'd23:   p = 9'h013;
      6'd24:   p = 9'h112;
      6'd25:   p = 9'h052;
      6'd26:   p = 9'h007;
      6'd27:   p = 9'h106;
      6'd28:   p = 9'h046;
      6'd29:   p = 9'h016;
      6'd30:   p = 9'h181;
      6'd31:   p = 9'h0C1;
      6'd32:   p = 9'h1C0;
      6'd33:   p = 9'h091;
      6'd34:   p = 9'h190;
      6'd35:   p = 9'h0D0;
      6'd36:   p = 9'h085;
      6'd37:   p = 9'h184;
      6'd38:   p = 9'h0C4;
      6'd39:   p = 9'h0A8;
      6'd40:   p = 9'h0A2;
      6'd41:   p = 9'h08A;
      6'd42:   p = 9'h02A;
      6'd43:   p = 9'h094;
      default: p = 9'h000;
    endcase
    return p;
  endfunction

endpackage

// ----- hdl/c39_front.sv -----
// Front end: classifies each character, keeps checksum and count, emits jobs.
`timescale 1ns / 1ps

module c39_front #(
  parameter int MaxChars = c39_pkg::MAX_CHARS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  c39_pkg::in_t  in_data,
  input  logic          check_en,
  input  logic          q_ready,
  output logic          q_push,
  output c39_pkg::job_t q_job
);
  import c39_pkg::*;

  localparam int CNT_W = $clog2(MaxChars + 1);

  logic [5:0]       sum_r, sum_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             in_msg_r, in_msg_nxt;
  logic             failed_r, failed_nxt;

  sym_t       s;
  logic       accept;
  logic       fail_now;
  logic [6:0] sum_add;
  logic [5:0] sum_new;

  assign in_stall = !q_ready;
  assign accept   = in_valid && q_ready;
  assign s        = c39_sym_of(in_data.char_code);
  assign fail_now = !s.valid || (count_r >= CNT_W'(MaxChars));

  // The star adds nothing; both operands stay below the modulus.
  always_comb begin
    sum_add = {1'b0, sum_r} + ((s.value == SYM_STAR) ? 7'd0 : {1'b0, s.value});
    if (sum_add >= 7'(MOD)) begin
      sum_new = 6'(sum_add - 7'(MOD));
    end else begin
      sum_new = sum_add[5:0];
    end
  end

  always_comb begin
    sum_nxt         = sum_r;
    count_nxt       = count_r;
    in_msg_nxt      = in_msg_r;
    failed_nxt      = failed_r;
    q_push          = 1'b0;
    q_job           = '0;
    q_job.sym       = s.value;
    q_job.check_sym = sum_new;
    if (accept) begin
      if (failed_r) begin
        if (in_data.last_char) begin
          failed_nxt = 1'b0;
          sum_nxt    = '0;
          count_nxt  = '0;
          in_msg_nxt = 1'b0;
        end
      end else if (fail_now) begin
        q_push    = 1'b1;
        q_job.err = 1'b1;
        if (in_data.last_char) begin
          sum_nxt    = '0;
          count_nxt  = '0;
          in_msg_nxt = 1'b0;
        end else begin
          failed_nxt = 1'b1;
        end
      end else begin
        q_push      = 1'b1;
        q_job.start = !in_msg_r;
        q_job.check = in_data.last_char && check_en;
        q_job.stop  = in_data.last_char;
        if (in_data.last_char) begin
          sum_nxt    = '0;
          count_nxt  = '0;
          in_msg_nxt = 1'b0;
        end else begin
          sum_nxt    = sum_new;
          count_nxt  = count_r + CNT_W'(1);
          in_msg_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r    <= '0;
      count_r  <= '0;
      in_msg_r <= 1'b0;
      failed_r <= 1'b0;
    end else begin
      sum_r    <= sum_nxt;
      count_r  <= count_nxt;
      in_msg_r <= in_msg_nxt;
      failed_r <= failed_nxt;
    end
  end

endmodule

// ----- hdl/c39_queue.sv -----
// Short job queue between the front end and the element sequencer.
`timescale 1ns / 1ps

module c39_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  c39_pkg::job_t push_job,
  output logic          ready,
  input  logic          pop,
  output logic          avail,
  output c39_pkg::job_t head
);
  import c39_pkg::*;

  localparam int AW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);

  job_t          mem_r [QDEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  assign ready = count_r != CW'(QDEPTH);
  assign avail = count_r != '0;
  assign head  = mem_r[rd_ptr_r];

  function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
    return (p == AW'(QDEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push && ready) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push && ready) begin
        wr_ptr_r <= bump(wr_ptr_r);
      end
      if (pop && avail) begin
        rd_ptr_r <= bump(rd_ptr_r);
      end
      count_r <= count_r + CW'(push && ready) - CW'(pop && avail);
    end
  end

endmodule

// ----- hdl/c39_back.sv -----
// Back end: walks each job's patterns and sends one element per beat.
`timescale 1ns / 1ps

module c39_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [1:0]    wide_ratio,
  input  logic          q_avail,
  input  c39_pkg::job_t q_head,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_stall,
  output c39_pkg::out_t out_data
);
  import c39_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  job_t       job_r, job_nxt;
  logic       out_valid_r;
  out_t       out_data_r;

  logic       can_adv;
  logic       emit;
  logic       phase_end;
  logic       job_final;
  logic [5:0] cur_sym;
  logic [8:0] pat;
  logic [1:0] wide;
  out_t       elem;

  assign can_adv   = !out_valid_r || !out_stall;
  assign emit      = (phase_r != PH_IDLE) && can_adv;
  assign wide      = (wide_ratio < 2'd2) ? 2'd2 : wide_ratio;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Output side: which symbol is being drawn and what the current element is.
  always_comb begin
    cur_sym   = SYM_STAR;
    phase_end = 1'b0;
    job_final = 1'b0;
    case (phase_r)
      PH_ERR: begin
        phase_end = 1'b1;
        job_final = 1'b1;
      end
      PH_START: begin
        phase_end = cnt_r == 4'd9;
      end
      PH_DATA: begin
        cur_sym   = job_r.sym;
        phase_end = cnt_r == 4'd9;
        job_final = phase_end && !job_r.stop;
      end
      PH_CHECK: begin
        cur_sym   = job_r.check_sym;
        phase_end = cnt_r == 4'd9;
      end
      PH_STOP: begin
        phase_end = cnt_r == 4'd8;
        job_final = phase_end;
      end
      default: begin
        phase_end = 1'b0;
      end
    endcase
    pat  = c39_pattern(cur_sym);
    elem = '0;
    if (phase_r == PH_ERR) begin
      elem.error = 1'b1;
    end else if (cnt_r == 4'd9) begin
      elem.element_width = 2'd1;
    end else begin
      elem.element_width = pat[4'd8 - cnt_r] ? wide : 2'd1;
      elem.is_bar        = ~cnt_r[0];
    end
    elem.last = job_final;
  end

  // Next-state side: step through the job, pull the next one at its end.
  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    job_nxt   = job_r;
    q_pop     = 1'b0;
    if (emit) begin
      cnt_nxt = phase_end ? 4'd0 : cnt_r + 4'd1;
      if (phase_end) begin
        case (phase_r)
          PH_START: phase_nxt = PH_DATA;
          PH_DATA:  phase_nxt = job_r.check ? PH_CHECK : (job_r.stop ? PH_STOP : PH_IDLE);
          PH_CHECK: phase_nxt = PH_STOP;
          default:  phase_nxt = PH_IDLE;
        endcase
      end
    end
    if ((phase_r == PH_IDLE || (emit && job_final)) && q_avail) begin
      q_pop     = 1'b1;
      job_nxt   = q_head;
      cnt_nxt   = 4'd0;
      if (q_head.err) begin
        phase_nxt = PH_ERR;
      end else if (q_head.start) begin
        phase_nxt = PH_START;
      end else begin
        phase_nxt = PH_DATA;
      end
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
    if (can_adv) begin
      out_data_r <= elem;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      cnt_r       <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      if (can_adv) begin
        out_valid_r <= phase_r != PH_IDLE;
      end
    end
  end

endmodule

// ----- hdl/code39_barcode_encoder_core.sv -----
// Top level of the Code 39 encoder with optional mod-43 check character.
`timescale 1ns / 1ps

// Each input beat carries one message character and yields the bar and space
// elements it causes, one element per output beat, most significant pattern
// bit first. A character costs ten output beats (nine pattern elements and a
// narrow gap); the first character of a message adds ten beats for the start
// pattern, and the character marked last adds ten beats for the check
// character when enabled plus nine for the stop pattern. The element
// sequencer sends one element per clock while out_stall is low, so that
// sequencer sets the sustained rate. A bad character, or one beyond MaxChars,
// yields a single error beat and the rest of the message is dropped with no
// output, up to and including the beat marked last. The front end takes a new
// character every cycle while the two-entry job queue has room, so input and
// output stall independently. Configuration writes must only happen while the
// block is idle.
module code39_barcode_encoder_core #(
  parameter int MaxChars = c39_pkg::MAX_CHARS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  c39_pkg::in_t                      in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output c39_pkg::out_t                     out_data,
  input  logic                              cfg_we,
  input  logic [c39_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [1:0]                        cfg_wdata
);
  import c39_pkg::*;

  logic [1:0] wide_ratio_r;
  logic       check_en_r;

  logic q_ready;
  logic q_push;
  logic q_pop;
  logic q_avail;
  job_t q_job;
  job_t q_head;

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wide_ratio_r <= 2'd3;
      check_en_r   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WIDE_RATIO: wide_ratio_r <= cfg_wdata;
        CFG_CHECK_EN:   check_en_r   <= cfg_wdata[0];
        default:        wide_ratio_r <= wide_ratio_r;
      endcase
    end
  end

  // Front end: validates characters and tracks checksum and length.
  c39_front #(
    .MaxChars(MaxChars)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .check_en (check_en_r),
    .q_ready  (q_ready),
    .q_push   (q_push),
    .q_job    (q_job)
  );

  // Decouples classification from element generation.
  c39_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_job),
    .ready    (q_ready),
    .pop      (q_pop),
    .avail    (q_avail),
    .head     (q_head)
  );

  // Back end: emits elements into a registered output stage.
  c39_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .wide_ratio (wide_ratio_r),
    .q_avail    (q_avail),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule
